[hdl/magnet_uri_stream_parser_assert.svh]
// ----------------------------------------------------------------------------
// magnet_uri_stream_parser_assert
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef MAGNET_URI_STREAM_PARSER_ASSERT_SVH
`define MAGNET_URI_STREAM_PARSER_ASSERT_SVH
// Same-cycle implication, sampled on clk, off during rst.
`define MUP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, sampled on clk, off during rst.
`define MUP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[hdl/mup_pkg.sv]
// ----------------------------------------------------------------------------
// mup_pkg
// Types, codes and character helpers of the magnet link parser.
// ----------------------------------------------------------------------------
package mup_pkg;

  localparam int NumSlots = 4;

  // parameter kinds held while a parameter is parsed
  localparam logic [2:0] PK_KEY   = 3'd0;
  localparam logic [2:0] PK_DN    = 3'd1;
  localparam logic [2:0] PK_TR    = 3'd2;
  localparam logic [2:0] PK_XT    = 3'd3;
  localparam logic [2:0] PK_XL    = 3'd4;
  localparam logic [2:0] PK_OTHER = 3'd5;

  // field kinds on the result side
  localparam logic [1:0] FK_NONE = 2'd0;
  localparam logic [1:0] FK_DN   = 2'd1;
  localparam logic [1:0] FK_TR   = 2'd2;
  localparam logic [1:0] FK_HASH = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_PREFIX   = 3'd1;
  localparam logic [2:0] ST_NO_HASH  = 3'd2;
  localparam logic [2:0] ST_BAD_HASH = 3'd3;
  localparam logic [2:0] ST_BAD_SIZE = 3'd4;
  localparam logic [2:0] ST_ESCAPE   = 3'd5;

  // committed hash formats
  localparam logic [1:0] HF_NONE    = 2'd0;
  localparam logic [1:0] HF_HEX     = 2'd1;
  localparam logic [1:0] HF_BASE32  = 2'd2;
  localparam logic [1:0] HF_INVALID = 2'd3;

  // escape phases
  localparam logic [1:0] EP_IDLE = 2'd0;
  localparam logic [1:0] EP_PCT  = 2'd1;
  localparam logic [1:0] EP_HELD = 2'd2;

  // size flag bits
  localparam int SzNeg  = 0;
  localparam int SzDig  = 1;
  localparam int SzStop = 2;
  localparam int SzSeen = 3;

  localparam logic [63:0] LimitPos = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LimitNeg = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic [1:0] kind;
    logic       fend;
    logic       commit;
  } item_t;

  typedef struct packed {
    item_t [NumSlots-1:0] items;
    logic [1:0]           count;   // field items in use
    logic                 done;    // a link_done item follows them
    logic [2:0]           status;
    logic [63:0]          size;
    logic [1:0]           format;
  } entry_t;

  typedef struct packed {
    logic [3:0]  prefix_pos;
    logic [15:0] key_buffer;
    logic [1:0]  key_count;
    logic [2:0]  param_kind;
    logic [3:0]  pattern_pos;
    logic [5:0]  hash_count;
    logic        hash_all_hex;
    logic        hash_all_base32;
    logic [1:0]  committed_format;
    logic [1:0]  escape_phase;
    logic [7:0]  escape_held;
    logic [63:0] size_accum;
    logic [3:0]  size_flags;
    logic [63:0] saved_size;
    logic [2:0]  error_code;
  } parse_t;

  localparam parse_t PARSE_RESET = '{
    prefix_pos: 4'd0, key_buffer: 16'd0, key_count: 2'd0, param_kind: PK_KEY,
    pattern_pos: 4'd0, hash_count: 6'd0, hash_all_hex: 1'b1,
    hash_all_base32: 1'b1, committed_format: HF_NONE, escape_phase: EP_IDLE,
    escape_held: 8'd0, size_accum: 64'd0, size_flags: 4'd0, saved_size: 64'd0,
    error_code: ST_OK};

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    if (c >= "0" && c <= "9") r = {1'b0, 4'(c - "0")};
    else if (c >= "a" && c <= "f") r = {1'b0, 4'(c - "a" + 8'd10)};
    else if (c >= "A" && c <= "F") r = {1'b0, 4'(c - "A" + 8'd10)};
    else r = 5'b10000;
    return r;
  endfunction

  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0: c = "m";
      3'd1: c = "a";
      3'd2: c = "g";
      3'd3: c = "n";
      3'd4: c = "e";
      3'd5: c = "t";
      3'd6: c = ":";
      default: c = "?";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] urn_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0: c = "u";
      4'd1: c = "r";
      4'd2: c = "n";
      4'd3: c = ":";
      4'd4: c = "b";
      4'd5: c = "t";
      4'd6: c = "i";
      4'd7: c = "h";
      default: c = ":";
    endcase
    return c;
  endfunction

endpackage

[hdl/mup_front.sv]
// ----------------------------------------------------------------------------
// mup_front
// Takes one link byte a cycle while accept is high, updates parser state, builds a queue entry.
// ----------------------------------------------------------------------------
module mup_front import mup_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       end_of_link,
  output logic       push,
  output entry_t     entry
);

  parse_t st, st_next;

  always_comb begin
    parse_t     s;
    entry_t     e;
    logic [1:0] n;
    logic       do_end;
    logic [4:0] hi, lo;
    logic [7:0] b, hb;
    logic [67:0] prod;
    logic [63:0] limit;
    logic [2:0] stat;
    s = st;
    e = '0;
    n = 2'd0;
    do_end = 1'b0;
    b = in_byte;
    hi = hex_val(s.escape_held);
    lo = hex_val(b);
    hb = s.escape_held;
    prod = '0;
    limit = LimitPos;
    stat = ST_OK;
    if (accept) begin
      if (s.error_code == ST_OK) begin
        if (!s.prefix_pos[3]) begin
          if (b == prefix_char(s.prefix_pos[2:0])) s.prefix_pos = s.prefix_pos + 4'd1;
          else s.error_code = ST_PREFIX;
        end else if (b == "&") begin
          do_end = 1'b1;
        end else begin
          case (s.param_kind)
            PK_KEY: begin
              if (s.key_count < 2'd2) begin
                s.key_buffer = {s.key_buffer[7:0], b};
                s.key_count = s.key_count + 2'd1;
              end else begin
                s.key_count = 2'd3;
                s.param_kind = PK_OTHER;
                if (b == "=") begin
                  if (s.key_buffer == "dn") s.param_kind = PK_DN;
                  else if (s.key_buffer == "tr") s.param_kind = PK_TR;
                  else if (s.key_buffer == "xt") s.param_kind = PK_XT;
                  else if (s.key_buffer == "xl") s.param_kind = PK_XL;
                end
              end
            end
            PK_DN: begin
              e.items[n] = '{1'b1, b, FK_DN, 1'b0, 1'b0};
              n = n + 2'd1;
            end
            PK_TR: begin
              if (s.escape_phase == EP_IDLE) begin
                if (b == "%") s.escape_phase = EP_PCT;
                else begin
                  e.items[n] = '{1'b1, (b == "+") ? 8'h20 : b, FK_TR, 1'b0, 1'b0};
                  n = n + 2'd1;
                end
              end else if (s.escape_phase == EP_PCT) begin
                s.escape_held = b;
                s.escape_phase = EP_HELD;
              end else begin
                s.escape_phase = EP_IDLE;
                if (hi[4]) s.error_code = ST_ESCAPE;
                else begin
                  e.items[n] = '{1'b1, lo[4] ? {4'd0, hi[3:0]} : {hi[3:0], lo[3:0]},
                                 FK_TR, 1'b0, 1'b0};
                  n = n + 2'd1;
                end
              end
            end
            PK_XT: begin
              if (s.pattern_pos < 4'd9) begin
                if (b == urn_char(s.pattern_pos)) s.pattern_pos = s.pattern_pos + 4'd1;
                else s.pattern_pos = (b == "u") ? 4'd1 : 4'd0;
              end else begin
                if (s.hash_count != 6'd63) s.hash_count = s.hash_count + 6'd1;
                if (lo[4]) s.hash_all_hex = 1'b0;
                if (!((b >= "A" && b <= "Z") || (b >= "2" && b <= "7")))
                  s.hash_all_base32 = 1'b0;
                e.items[n] = '{1'b1, b, FK_HASH, 1'b0, 1'b0};
                n = n + 2'd1;
              end
            end
            PK_XL: begin
              if (!s.size_flags[SzStop]) begin
                if (!s.size_flags[SzSeen] && (b == "+" || b == "-")) begin
                  s.size_flags[SzSeen] = 1'b1;
                  if (b == "-") s.size_flags[SzNeg] = 1'b1;
                end else if (b >= "0" && b <= "9") begin
                  limit = s.size_flags[SzNeg] ? LimitNeg : LimitPos;
                  prod = {1'b0, s.size_accum, 3'b0} + {3'b0, s.size_accum, 1'b0}
                       + {60'd0, 8'(b - "0")};
                  s.size_flags[SzSeen] = 1'b1;
                  if (prod > {4'd0, limit}) s.error_code = ST_BAD_SIZE;
                  else begin
                    s.size_accum = prod[63:0];
                    s.size_flags[SzDig] = 1'b1;
                  end
                end else begin
                  s.size_flags[SzSeen] = 1'b1;
                  s.size_flags[SzStop] = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      if (end_of_link && s.error_code == ST_OK) begin
        if (!s.prefix_pos[3]) s.error_code = ST_PREFIX;
        else do_end = 1'b1;
      end
      if (do_end) begin
        hb = s.escape_held;
        case (s.param_kind)
          PK_DN: begin
            e.items[n] = '{1'b0, 8'd0, FK_DN, 1'b1, 1'b0};
            n = n + 2'd1;
          end
          PK_TR: begin
            if (s.escape_phase != EP_IDLE) begin
              e.items[n] = '{1'b1, "%", FK_TR, 1'b0, 1'b0};
              n = n + 2'd1;
            end
            if (s.escape_phase == EP_HELD) begin
              e.items[n] = '{1'b1, (hb == "+") ? 8'h20 : hb, FK_TR, 1'b0, 1'b0};
              n = n + 2'd1;
            end
            e.items[n] = '{1'b0, 8'd0, FK_TR, 1'b1, 1'b0};
            n = n + 2'd1;
          end
          PK_XT: begin
            if (s.pattern_pos == 4'd9) begin
              if (s.hash_count == 6'd0) s.committed_format = HF_NONE;
              else if (s.hash_count == 6'd40 && s.hash_all_hex) s.committed_format = HF_HEX;
              else if (s.hash_count == 6'd32 && s.hash_all_base32)
                s.committed_format = HF_BASE32;
              else s.committed_format = HF_INVALID;
              e.items[n] = '{1'b0, 8'd0, FK_HASH, 1'b1, 1'b1};
              n = n + 2'd1;
            end
          end
          PK_XL: begin
            if (!s.size_flags[SzDig]) s.error_code = ST_BAD_SIZE;
            else s.saved_size = s.size_flags[SzNeg] ? (64'd0 - s.size_accum) : s.size_accum;
          end
          default: ;
        endcase
        // parameter scratch back to its idle values
        s.param_kind = PARSE_RESET.param_kind;
        s.key_count = PARSE_RESET.key_count;
        s.key_buffer = PARSE_RESET.key_buffer;
        s.pattern_pos = PARSE_RESET.pattern_pos;
        s.hash_count = PARSE_RESET.hash_count;
        s.hash_all_hex = PARSE_RESET.hash_all_hex;
        s.hash_all_base32 = PARSE_RESET.hash_all_base32;
        s.escape_phase = PARSE_RESET.escape_phase;
        s.escape_held = PARSE_RESET.escape_held;
        s.size_accum = PARSE_RESET.size_accum;
        s.size_flags = PARSE_RESET.size_flags;
      end
      if (end_of_link) begin
        stat = s.error_code;
        if (stat == ST_OK) begin
          if (s.committed_format == HF_NONE) stat = ST_NO_HASH;
          else if (s.committed_format == HF_INVALID) stat = ST_BAD_HASH;
        end
        e.done = 1'b1;
        e.status = stat;
        e.size = (stat == ST_OK) ? s.saved_size : 64'd0;
        e.format = (stat == ST_OK) ? s.committed_format : HF_NONE;
        s = PARSE_RESET;
      end
    end
    e.count = n;
    st_next = s;
    entry = e;
    push = accept && (n != 2'd0 || e.done);
  end

  always_ff @(posedge clk) begin
    if (rst) st <= PARSE_RESET;
    else st <= st_next;
  end

endmodule

[hdl/mup_queue.sv]
// ----------------------------------------------------------------------------
// mup_queue
// Two-entry queue between the parser front and the result back end.
// ----------------------------------------------------------------------------
module mup_queue import mup_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   full,
  output logic   head_valid,
  output entry_t head
);

  entry_t     slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;

  assign full = fill == 2'd2;
  assign head_valid = fill != 2'd0;
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[hdl/mup_back.sv]
// ----------------------------------------------------------------------------
// mup_back
// Walks the head entry one result word a cycle while res_stall is low and drives the result port.
// ----------------------------------------------------------------------------
module mup_back import mup_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  entry_t      head,
  output logic        pop,
  output logic        res_valid,
  input  logic        res_stall,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic [1:0]  field_kind,
  output logic        field_end,
  output logic        hash_commit,
  output logic        link_done,
  output logic [2:0]  status,
  output logic signed [63:0] file_size,
  output logic [1:0]  hash_format,
  output logic        last_of_run
);

  logic [1:0] idx;
  logic [2:0] total;
  logic       is_done;
  item_t      cur;

  assign total = {1'b0, head.count} + {2'b0, head.done};
  assign is_done = {1'b0, idx} == {1'b0, head.count};
  assign cur = is_done ? item_t'('0) : head.items[idx];
  assign last_of_run = {1'b0, idx} == total - 3'd1;
  assign res_valid = head_valid;
  assign pop = head_valid && !res_stall && last_of_run;

  assign out_valid = cur.valid;
  assign out_byte = cur.data;
  assign field_kind = cur.kind;
  assign field_end = cur.fend;
  assign hash_commit = cur.commit;
  assign link_done = is_done;
  assign status = is_done ? head.status : ST_OK;
  assign file_size = is_done ? head.size : 64'sd0;
  assign hash_format = is_done ? head.format : HF_NONE;

  always_ff @(posedge clk) begin
    if (rst) idx <= 2'd0;
    else if (head_valid && !res_stall) idx <= last_of_run ? 2'd0 : idx + 2'd1;
  end

endmodule

[hdl/magnet_uri_stream_parser.sv]
// ----------------------------------------------------------------------------
// magnet_uri_stream_parser
// Streaming magnet link parser: prefix check, parameter split, field decode.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     in_valid / in_stall    in_byte, end_of_link
//  result    res_valid / res_stall  out_valid .. last_of_run (ten fields)
//
//  One link byte is taken every cycle the queue is not full; its zero to
//  four result words leave one per cycle while res_stall is low, from the
//  head of a two-entry queue. Input stalls only while the queue holds two
//  entries.
//  Front state updates in the same cycle a byte is accepted; the size digit
//  step is one 68-bit multiply-by-ten add and compare.
//  rst (synchronous) clears parser state, queue pointers and word index.
// ----------------------------------------------------------------------------
module magnet_uri_stream_parser import mup_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        end_of_link,
  output logic        res_valid,
  input  logic        res_stall,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic [1:0]  field_kind,
  output logic        field_end,
  output logic        hash_commit,
  output logic        link_done,
  output logic [2:0]  status,
  output logic signed [63:0] file_size,
  output logic [1:0]  hash_format,
  output logic        last_of_run
);

  logic   accept, push, pop, full, head_valid;
  entry_t entry, head;

  // queue full is the only back-pressure on the link side
  assign in_stall = full;
  assign accept = in_valid && !full;

  mup_front u_front (
    .clk, .rst, .accept, .in_byte, .end_of_link, .push, .entry
  );

  mup_queue u_queue (
    .clk, .rst, .push, .push_entry(entry), .pop, .full, .head_valid, .head
  );

  mup_back u_back (
    .clk, .rst, .head_valid, .head, .pop, .res_valid, .res_stall,
    .out_valid, .out_byte, .field_kind, .field_end, .hash_commit,
    .link_done, .status, .file_size, .hash_format, .last_of_run
  );

endmodule

[hdl/mup_checker.sv]
// ----------------------------------------------------------------------------
// mup_checker
// Port-level checks on the result channel of the parser.
// ----------------------------------------------------------------------------
`include "magnet_uri_stream_parser_assert.svh"
module mup_checker import mup_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_stall,
  input logic        out_valid,
  input logic [1:0]  field_kind,
  input logic        link_done,
  input logic [2:0]  status,
  input logic signed [63:0] file_size,
  input logic [1:0]  hash_format,
  input logic        last_of_run
);

  logic done_word, field_word, no_summary;

  assign done_word = res_valid && link_done;
  assign field_word = res_valid && !link_done;
  assign no_summary = file_size == 64'sd0 && hash_format == HF_NONE;

  `MUP_ASSERT_NEXT(a_valid_holds, res_valid && res_stall, res_valid)
  `MUP_ASSERT_NOW(a_done_is_last, done_word, last_of_run)
  `MUP_ASSERT_NOW(a_done_no_field, done_word, !out_valid && field_kind == FK_NONE)
  `MUP_ASSERT_NOW(a_err_no_size, done_word && status != ST_OK, no_summary)
  `MUP_ASSERT_NOW(a_status_on_done, field_word, status == ST_OK && hash_format == HF_NONE)

endmodule

bind magnet_uri_stream_parser mup_checker u_mup_checker (
  .clk, .rst, .res_valid, .res_stall, .out_valid, .field_kind, .link_done,
  .status, .file_size, .hash_format, .last_of_run
);
